FILE: rtl/itcw_pkg.sv
// ----------------------------------------------------------------------------
// itcw_pkg
// Types and constants shared by the isochronous TRB control word builder.
// ----------------------------------------------------------------------------
package itcw_pkg;

    localparam int REQ_W    = 16;
    localparam int FRAME_W  = 16;
    localparam int FRID_W   = 11;
    localparam int MPS_W    = 11;
    localparam int BURST_W  = 5;
    localparam int PKT_W    = 16;
    localparam int TBC_W    = 2;
    localparam int TLBPC_W  = 4;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // divider: dividend width, two quotient bits a step
    localparam int DIVD_W    = 18;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int CNT_W     = 4;

    localparam logic [5:0] TRB_TYPE_ISOCH = 6'd5;

    localparam logic [MPS_W-1:0]   MPS_RESET   = 11'd1024;
    localparam logic [BURST_W-1:0] BURST_RESET = 5'd1;
    localparam logic [BURST_W-1:0] BURST_MAX   = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BURST         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_STREAM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PKT,
        ST_BURST_LOAD,
        ST_DIV_BURST,
        ST_FINISH
    } itcw_state_t;

    typedef struct packed {
        logic load_pkt;
        logic load_burst;
        logic step;
        logic load_out;
    } itcw_cmd_t;

    typedef struct packed {
        logic last_step;
    } itcw_status_t;

endpackage

FILE: rtl/itcw_datapath.sv
// ----------------------------------------------------------------------------
// itcw_datapath
// Shared radix-4 restoring divider, packet and burst results, dword packing.
// ----------------------------------------------------------------------------
module itcw_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itcw_pkg::itcw_cmd_t                 cmd,
    output itcw_pkg::itcw_status_t              status,
    input  logic [itcw_pkg::REQ_W-1:0]          req_count,
    input  logic [itcw_pkg::FRAME_W-1:0]        frame_number,
    input  logic                                use_frame,
    input  logic [itcw_pkg::MPS_W-1:0]          mps_eff,
    input  logic [itcw_pkg::BURST_W-1:0]        burst_eff,
    output logic [itcw_pkg::WORD_W-1:0]         control_word,
    output logic [itcw_pkg::PKT_W-1:0]          packet_count,
    output logic [itcw_pkg::TBC_W-1:0]          burst_count,
    output logic [itcw_pkg::TLBPC_W-1:0]        last_burst_packets
);
    import itcw_pkg::*;

    logic [DIVD_W-1:0]  dividend_reg, dividend_next;
    logic [MPS_W-1:0]   rem_reg, rem_next;
    logic [DIVD_W-1:0]  quot_reg, quot_next;
    logic [MPS_W-1:0]   divisor_reg, divisor_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PKT_W-1:0]   pkts_reg;
    logic               use_frame_reg;
    logic [FRID_W-1:0]  frame_id_reg;

    logic [MPS_W:0]     t1, t2;
    logic               ge1, ge2;
    logic [MPS_W-1:0]   r1, r2;
    logic [REQ_W:0]     pkt_dividend;
    logic [PKT_W-1:0]   pkts_eff;

    logic [WORD_W-1:0]  word_reg;
    logic [PKT_W-1:0]   pkt_out_reg;
    logic [TBC_W-1:0]   tbc_out_reg;
    logic [TLBPC_W-1:0] tlbpc_out_reg;

    always_comb
    begin
        t1  = {rem_reg, dividend_reg[DIVD_W-1]};
        ge1 = (t1 >= {1'b0, divisor_reg});
        r1  = ge1 ? MPS_W'(t1 - {1'b0, divisor_reg}) : t1[MPS_W-1:0];
        t2  = {r1, dividend_reg[DIVD_W-2]};
        ge2 = (t2 >= {1'b0, divisor_reg});
        r2  = ge2 ? MPS_W'(t2 - {1'b0, divisor_reg}) : t2[MPS_W-1:0];

        pkt_dividend = {1'b0, req_count} + {{(REQ_W+1-MPS_W){1'b0}}, mps_eff}
                       - {{REQ_W{1'b0}}, 1'b1};
        pkts_eff = (quot_reg[PKT_W-1:0] == '0) ? PKT_W'(1) : quot_reg[PKT_W-1:0];

        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        divisor_next  = divisor_reg;
        count_next    = count_reg;

        if (cmd.load_pkt)
        begin
            dividend_next = {{(DIVD_W-REQ_W-1){1'b0}}, pkt_dividend};
            rem_next      = '0;
            quot_next     = '0;
            divisor_next  = mps_eff;
            count_next    = CNT_W'(DIV_STEPS - 1);
        end
        else if (cmd.load_burst)
        begin
            dividend_next = {{(DIVD_W-PKT_W){1'b0}}, PKT_W'(pkts_eff - PKT_W'(1))};
            rem_next      = '0;
            quot_next     = '0;
            divisor_next  = {{(MPS_W-BURST_W){1'b0}}, burst_eff};
            count_next    = CNT_W'(DIV_STEPS - 1);
        end
        else if (cmd.step)
        begin
            dividend_next = {dividend_reg[DIVD_W-3:0], 2'b00};
            rem_next      = r2;
            quot_next     = {quot_reg[DIVD_W-3:0], ge1, ge2};
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        divisor_reg  <= divisor_next;
        if (cmd.load_pkt)
        begin
            use_frame_reg <= use_frame;
            frame_id_reg  <= frame_number[FRID_W-1:0];
        end
        if (cmd.load_burst)
        begin
            pkts_reg <= pkts_eff;
        end
        if (cmd.load_out)
        begin
            pkt_out_reg   <= pkts_reg;
            tbc_out_reg   <= quot_reg[TBC_W-1:0];
            tlbpc_out_reg <= rem_reg[TLBPC_W-1:0];
            word_reg      <= {!use_frame_reg,
                              use_frame_reg ? frame_id_reg : {FRID_W{1'b0}},
                              rem_reg[TLBPC_W-1:0],
                              TRB_TYPE_ISOCH,
                              1'b0,
                              quot_reg[TBC_W-1:0],
                              7'd0};
        end
    end

    assign status.last_step   = (count_reg == '0);
    assign control_word       = word_reg;
    assign packet_count       = pkt_out_reg;
    assign burst_count        = tbc_out_reg;
    assign last_burst_packets = tlbpc_out_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pkt || cmd.load_burst) |=> (divisor_reg != '0))
        else $error("divisor loaded as zero");

    a_burst_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_burst |=> (divisor_reg <= MPS_W'(BURST_MAX)))
        else $error("burst divisor above sixteen");

endmodule

FILE: rtl/itcw_ctrl.sv
// ----------------------------------------------------------------------------
// itcw_ctrl
// Sequencer for the two divisions and the output register handshake.
// ----------------------------------------------------------------------------
module itcw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output itcw_pkg::itcw_cmd_t    cmd,
    input  itcw_pkg::itcw_status_t status
);
    import itcw_pkg::*;

    itcw_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pkt = 1'b1;
                    state_next   = ST_DIV_PKT;
                end
            end
            ST_DIV_PKT:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_BURST_LOAD;
                end
            end
            ST_BURST_LOAD:
            begin
                cmd.load_burst = 1'b1;
                state_next     = ST_DIV_BURST;
            end
            ST_DIV_BURST:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result loaded without valid");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_pkt, cmd.load_burst, cmd.step, cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

FILE: rtl/isoch_trb_control_word.sv
// ----------------------------------------------------------------------------
// isoch_trb_control_word
// Builds the fourth control dword of an isochronous transfer TRB.
// ----------------------------------------------------------------------------
// One transfer is processed at a time. The packet count and then the burst
// split run through one shared divider that resolves two quotient bits a
// cycle. Each division starts with a load of the divider, and the result is
// then loaded into the output register. A new input transfer is taken only
// once the previous one has left the divider for the output register.
// The result sits in an output register, so the next input transfer is taken
// while the previous result still waits. That next result then holds in its
// last state until the output register is free. Configuration writes are
// taken in every cycle and must only be made while no transfer is in flight.
// ----------------------------------------------------------------------------
module isoch_trb_control_word (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // req_count, frame_number
    input  logic                               s_tuser,  // first_of_td
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // control_word, packet_count, burst_count, last_burst_packets, zero pad
    output logic [55:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [itcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [itcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import itcw_pkg::*;

    logic [MPS_W-1:0]   mps_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               continuous_reg;
    logic               started_reg;

    logic [MPS_W-1:0]   mps_eff;
    logic [BURST_W-1:0] burst_eff;
    logic               use_frame;
    logic               in_xfer;

    itcw_cmd_t          cmd;
    itcw_status_t       status;

    logic [WORD_W-1:0]  control_word;
    logic [PKT_W-1:0]   packet_count;
    logic [TBC_W-1:0]   burst_count;
    logic [TLBPC_W-1:0] last_burst_packets;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mps_reg        <= MPS_RESET;
            burst_reg      <= BURST_RESET;
            continuous_reg <= 1'b0;
            started_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MAX_PACKET_SIZE:   mps_reg        <= cfg_data[MPS_W-1:0];
                    CFG_MAX_BURST:         burst_reg      <= cfg_data[BURST_W-1:0];
                    CFG_CONTINUOUS_STREAM: continuous_reg <= cfg_data[0];
                    default:               ;
                endcase
            end
            if (in_xfer)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        mps_eff = (mps_reg == '0) ? MPS_W'(1) : mps_reg;
        if (burst_reg == '0)
        begin
            burst_eff = BURST_W'(1);
        end
        else if (burst_reg > BURST_MAX)
        begin
            burst_eff = BURST_MAX;
        end
        else
        begin
            burst_eff = burst_reg;
        end
        use_frame = continuous_reg ? !started_reg : s_tuser;
    end

    itcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    itcw_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req_count          (s_tdata[REQ_W-1:0]),
        .frame_number       (s_tdata[REQ_W+FRAME_W-1:REQ_W]),
        .use_frame          (use_frame),
        .mps_eff            (mps_eff),
        .burst_eff          (burst_eff),
        .control_word       (control_word),
        .packet_count       (packet_count),
        .burst_count        (burst_count),
        .last_burst_packets (last_burst_packets)
    );

    assign m_tdata = {2'b00, last_burst_packets, burst_count, packet_count, control_word};

    a_started_set: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> started_reg)
        else $error("stream start flag not set after transfer");

endmodule

FILE: tb/trb_word_checker.sv
// ----------------------------------------------------------------------------
// trb_word_checker
// Predicts and checks the isochronous TRB control dword for every transfer.
// ----------------------------------------------------------------------------
// Watches the input, output and configuration channels of the control word
// builder. Each accepted input transfer is turned into an expected dword,
// packet count, burst count and last-burst packet count, using a private copy
// of the registers and of the stream-started flag. Each accepted output
// transfer is compared field by field with the oldest expectation. The count
// of failures and of outstanding expectations goes back to the top level.
// ----------------------------------------------------------------------------
module trb_word_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // req_count, frame_number
    input  logic                            s_tuser,  // first_of_td
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // control_word, packet_count, burst_count, last_burst_packets, zero pad
    input  logic [55:0]                     m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [itcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [itcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              outstanding
);
    import itcw_pkg::*;

    localparam int TYPE_LSB  = 10;
    localparam int TBC_LSB   = 7;
    localparam int TLBPC_LSB = 16;
    localparam int FRID_LSB  = 20;
    localparam int SIA_POS   = 31;

    typedef struct packed {
        logic [WORD_W-1:0]  control_word;
        logic [PKT_W-1:0]   packet_count;
        logic [TBC_W-1:0]   burst_count;
        logic [TLBPC_W-1:0] last_burst_packets;
    } trb_result_t;

    logic [MPS_W-1:0]   packet_size;
    logic [BURST_W-1:0] burst_size;
    logic               continuous;
    logic               stream_started;
    trb_result_t        pending_words[$];
    int                 fail_total;

    function automatic trb_result_t build_trb_word(input logic [REQ_W-1:0]   req,
                                                   input logic               first,
                                                   input logic [FRAME_W-1:0] frame);
        int unsigned mps;
        int unsigned burst;
        int unsigned pkts;
        int unsigned resid;
        trb_result_t r;
        mps   = (packet_size == '0) ? 32'd1 : 32'(packet_size);
        burst = (burst_size == '0) ? 32'd1 : 32'(burst_size);
        if (burst > 32'(BURST_MAX))
            burst = 32'(BURST_MAX);
        pkts = (int'(req) + mps - 1) / mps;
        if (pkts == 0)
            pkts = 1;
        resid = pkts % burst;
        r.packet_count       = PKT_W'(pkts);
        r.burst_count        = TBC_W'((pkts + burst - 1) / burst - 1);
        r.last_burst_packets = TLBPC_W'((resid != 0) ? resid - 1 : burst - 1);
        r.control_word       = '0;
        r.control_word[TYPE_LSB +: 6]        = TRB_TYPE_ISOCH;
        r.control_word[TBC_LSB +: TBC_W]     = r.burst_count;
        r.control_word[TLBPC_LSB +: TLBPC_W] = r.last_burst_packets;
        if (continuous ? !stream_started : first)
            r.control_word[FRID_LSB +: FRID_W] = frame[FRID_W-1:0];
        else
            r.control_word[SIA_POS] = 1'b1;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        fail_total++;
        if (fail_total <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        trb_result_t want;
        trb_result_t got;
        if (!rst_n)
        begin
            packet_size    = MPS_RESET;
            burst_size     = BURST_RESET;
            continuous     = 1'b0;
            stream_started = 1'b0;
            fail_total     = 0;
            pending_words.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.control_word       = m_tdata[31:0];
                got.packet_count       = m_tdata[47:32];
                got.burst_count        = m_tdata[49:48];
                got.last_burst_packets = m_tdata[53:50];
                if (pending_words.size() == 0)
                    note_mismatch("unexpected result", 0, m_tdata);
                else
                begin
                    want = pending_words.pop_front();
                    if (got.control_word != want.control_word)
                        note_mismatch("control_word", want.control_word,
                                      got.control_word);
                    if (got.packet_count != want.packet_count)
                        note_mismatch("packet_count", want.packet_count,
                                      got.packet_count);
                    if (got.burst_count != want.burst_count)
                        note_mismatch("burst_count", want.burst_count,
                                      got.burst_count);
                    if (got.last_burst_packets != want.last_burst_packets)
                        note_mismatch("last_burst_packets", want.last_burst_packets,
                                      got.last_burst_packets);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_PACKET_SIZE:   packet_size = cfg_data[MPS_W-1:0];
                    CFG_MAX_BURST:         burst_size  = cfg_data[BURST_W-1:0];
                    CFG_CONTINUOUS_STREAM: continuous  = cfg_data[0];
                    default:               ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                pending_words.push_back(build_trb_word(s_tdata[15:0], s_tuser,
                                                       s_tdata[31:16]));
                stream_started = 1'b1;
            end
            errors      <= fail_total;
            outstanding <= pending_words.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the isochronous TRB control word builder.
// ----------------------------------------------------------------------------
// Drives a directed set of transfers and register settings covering the
// extremes of the byte count, packet size and burst size, then random
// transfers under a series of random settings, in three phases. Input and
// output sides idle at random in the first two. A separate checker predicts
// every result and counts failures; the top reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import itcw_pkg::*;

    localparam int LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int cur_mps   = 1024;
    int cur_burst = 1;
    int errors;
    int outstanding;

    isoch_trb_control_word uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trb_word_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_transfer(input logic [REQ_W-1:0] req, input logic first,
                                 input logic [FRAME_W-1:0] frame);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {frame, req};
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input int mps, input int burst, input logic cont);
        write_reg(CFG_MAX_PACKET_SIZE, CFG_DATA_W'(mps));
        write_reg(CFG_MAX_BURST, CFG_DATA_W'(burst));
        write_reg(CFG_CONTINUOUS_STREAM, CFG_DATA_W'(cont));
        cur_mps   = (mps == 0) ? 1 : mps;
        cur_burst = (burst == 0) ? 1 : (burst > 16) ? 16 : burst;
    endtask

    task automatic random_config();
        int mps;
        int burst;
        case ($urandom_range(6))
            0:       mps = 0;
            1:       mps = 1;
            2:       mps = 1024;
            3:       mps = 2047;
            4:       mps = $urandom_range(1025, 2047);
            default: mps = $urandom_range(1, 1024);
        endcase
        case ($urandom_range(5))
            0:       burst = 0;
            1:       burst = $urandom_range(17, 31);
            2:       burst = 16;
            default: burst = $urandom_range(1, 16);
        endcase
        set_config(mps, burst, 1'($urandom_range(1)));
    endtask

    task automatic random_transfer();
        int span;
        int req;
        span = cur_mps * cur_burst * 5;
        if (span > 65535)
            span = 65535;
        case ($urandom_range(3))
            0: req = $urandom_range(65535);
            1: req = $urandom_range(span);
            2: req = cur_mps * $urandom_range(0, 4 * cur_burst) + $urandom_range(2) - 1;
            default: req = $urandom_range(2048);
        endcase
        if (req < 0)
            req = 0;
        if (req > 65535)
            req = 65535;
        send_transfer(REQ_W'(req), 1'($urandom_range(1)), FRAME_W'($urandom));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_CONTINUOUS_STREAM, CFG_DATA_W'(1));
        send_transfer(16'd100, 1'b0, 16'h0abc);
        send_transfer(16'd0, 1'b1, 16'hffff);
        wait_idle();
        write_reg(CFG_CONTINUOUS_STREAM, CFG_DATA_W'(0));

        send_transfer(16'hffff, 1'b1, 16'hffff);
        send_transfer(16'd1024, 1'b0, 16'h0000);
        send_transfer(16'd1025, 1'b1, 16'h1234);
        send_transfer(16'd1, 1'b1, 16'hf800);

        wait_idle();
        write_reg(CFG_SPARE, 11'h7ff);
        set_config(0, 0, 1'b0);
        send_transfer(16'd0, 1'b1, 16'h5555);
        send_transfer(16'hffff, 1'b0, 16'haaaa);
        send_transfer(16'd3, 1'b1, 16'h0007);

        wait_idle();
        set_config(1, 16, 1'b0);
        send_transfer(16'd16, 1'b1, 16'h07ff);
        send_transfer(16'd17, 1'b0, 16'h0800);
        send_transfer(16'd64, 1'b1, 16'h0123);
        send_transfer(16'd65, 1'b1, 16'hfedc);

        wait_idle();
        set_config(2047, 31, 1'b1);
        send_transfer(16'hffff, 1'b1, 16'h0321);
        send_transfer(16'd32752, 1'b1, 16'h0456);
        send_transfer(16'd32753, 1'b0, 16'h0789);

        wait_idle();
        set_config(1024, 5, 1'b0);
        send_transfer(16'd5120, 1'b1, 16'h0111);
        send_transfer(16'd20480, 1'b1, 16'h0222);
        send_transfer(16'd21504, 1'b0, 16'h0333);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
            stall_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                wait_idle();
                random_config();
                repeat (71) random_transfer();
            end
        end

        wait_idle();
        repeat (25) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
